### hw/rtl/eht_pkg.sv
// ----------------------------------------------------------------------------
// eht_pkg
// Shared sizes, codes and word types for the extendible hash table unit.
// ----------------------------------------------------------------------------
package eht_pkg;

  localparam int DIR_BITS    = 6;
  localparam int DIR_ENTRIES = 1 << DIR_BITS;
  localparam int SLOTS       = 4;
  localparam int SLOT_IW     = 2;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int SLOT_W      = KEY_W + VAL_W;
  localparam int ROW_W       = SLOTS * SLOT_W;
  localparam int LD_W        = 3;
  localparam int BKT_W       = LD_W + SLOTS + ROW_W;
  localparam int CNT_W       = 7;
  localparam int CAP_W       = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 3'd4;

  localparam logic [1:0] CMD_FIND   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_DEPTH  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_NOROOM = 2'd2;

  typedef struct packed {
    logic [1:0]          command;
    logic [KEY_W-1:0]    key;
    logic [VAL_W-1:0]    write_value;
    logic [DIR_BITS-1:0] dir_sel;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] read_value;
    logic [LD_W-1:0]  bkt_level;
    logic [LD_W-1:0]  dir_level;
    logic [CNT_W-1:0] bucket_count;
  } out_word_t;

endpackage

### hw/rtl/eht_ram.sv
// ----------------------------------------------------------------------------
// eht_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module eht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/extendible_hash_table_unit.sv
// ----------------------------------------------------------------------------
// extendible_hash_table_unit
// Key/value store with an extendible-hashing directory.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_ready, in_data) carry a command: find, insert or
// update, remove, or read the local depth behind a directory entry. Each word
// yields one result word on out_valid/out_ready with status, found value,
// local depth, global depth and bucket count.
// Find, remove, depth read and a plain insert pass after acceptance through
// directory read, bucket read, then the result register that sets out_valid.
// A depth read of an entry beyond the directory goes straight to the result
// register. A new word is taken the cycle after the result is loaded. An
// insert into a full bucket splits it: a second bucket write, a directory
// sweep, read then write, over every live entry after any doubling, a restart
// step, then the directory and bucket lookup again; up to 6 splits may chain.
// The single-read-port directory RAM sets the sweep length.
// State lives in a directory RAM and a bucket RAM (depth, slot flags, slots).
// Reset empties the table at once (a valid bit per directory entry and per
// bucket), sets capacity to 4 and needs no clearing pass.
// While out_ready is low a finished result holds in the output register; the
// next word is still accepted and held at its final step until the register
// frees. Write bucket_capacity via APB port only while idle; not enforced.
// ----------------------------------------------------------------------------
module extendible_hash_table_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  eht_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output eht_pkg::out_word_t   out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIR  = 4'd1;
  localparam logic [3:0] S_ROW  = 4'd2;
  localparam logic [3:0] S_DEP2 = 4'd3;
  localparam logic [3:0] S_SWR  = 4'd4;
  localparam logic [3:0] S_SWW  = 4'd5;
  localparam logic [3:0] S_LOOK = 4'd6;
  localparam logic [3:0] S_RESP = 4'd7;

  localparam int DB = eht_pkg::DIR_BITS;
  localparam int SW = eht_pkg::SLOT_W;
  localparam int VW = eht_pkg::VAL_W;
  localparam int KW = eht_pkg::KEY_W;
  localparam int NS = eht_pkg::SLOTS;
  localparam int IW = eht_pkg::SLOT_IW;
  localparam int RW = eht_pkg::ROW_W;
  localparam int LD_W_C = eht_pkg::LD_W;

  logic [3:0]                        state_r, state_nxt;
  logic [1:0]                        cmd_r;
  logic [KW-1:0]                     key_r;
  logic [VW-1:0]                     val_r;
  logic [LD_W_C-1:0]                 dd_r, dd_nxt;
  logic [eht_pkg::CNT_W-1:0]         biu_r, biu_nxt;
  logic [eht_pkg::CAP_W-1:0]         cap_r;
  logic [eht_pkg::DIR_ENTRIES-1:0]   dir_vld_r, bkt_vld_r;
  logic                              rd_dir_vld_r, rd_bkt_vld_r;
  logic [DB-1:0]                     b_r, b_nxt, nb_r, nb_nxt, i_r, i_nxt;
  logic [LD_W_C-1:0]                 bit_r, bit_nxt, ddold_r, ddold_nxt, ldn_r, ldn_nxt;
  logic                              dbl_r, dbl_nxt;
  logic [1:0]                        rst_st_r, rst_st_nxt;
  logic [VW-1:0]                     res_rv_r, res_rv_nxt;
  logic [LD_W_C-1:0]                 res_ld_r, res_ld_nxt;
  logic                              out_valid_r, out_valid_nxt;
  eht_pkg::out_word_t                out_data_r, out_data_nxt;

  logic                      dir_we, bkt_we;
  logic [DB-1:0]             dir_wa, dir_wd, dir_ra, dir_rd, dir_q;
  logic [DB-1:0]             bkt_wa, bkt_ra;
  logic [eht_pkg::BKT_W-1:0] bkt_wd, bkt_rd;
  logic [LD_W_C-1:0]         dep_q, dep_wr;
  logic [RW-1:0]             row_wd, row_rd, pk_row;
  logic [NS-1:0]             used_cur, used_wr, hit, mv, pk_used;
  logic [IW-1:0]             hit_idx, free_idx;
  logic [2:0]                cnt, cap_eff, pos;
  logic                      accept, split_fail, out_free;
  logic [DB-1:0]             lmask, omask;

  function automatic logic [DB-1:0] depth_mask(input logic [LD_W_C-1:0] d);
    logic [DB:0] one;
    one = (DB+1)'(1);
    return DB'((one << d) - one);
  endfunction

  eht_ram #(.WIDTH(DB), .DEPTH(eht_pkg::DIR_ENTRIES)) u_dir_ram (
    .clk(clk), .we(dir_we), .waddr(dir_wa), .wdata(dir_wd), .raddr(dir_ra), .rdata(dir_rd)
  );

  eht_ram #(.WIDTH(eht_pkg::BKT_W), .DEPTH(eht_pkg::DIR_ENTRIES)) u_bkt_ram (
    .clk(clk), .we(bkt_we), .waddr(bkt_wa), .wdata(bkt_wd), .raddr(bkt_ra), .rdata(bkt_rd)
  );

  assign dir_q     = rd_dir_vld_r ? dir_rd : '0;
  assign row_rd    = bkt_rd[RW-1:0];
  assign used_cur  = rd_bkt_vld_r ? bkt_rd[RW +: NS] : '0;
  assign dep_q     = rd_bkt_vld_r ? bkt_rd[RW+NS +: LD_W_C] : '0;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? 32'd0 : {29'd0, cap_r};
  assign lmask     = depth_mask(dd_r);
  assign omask     = depth_mask(ddold_r);
  assign out_free  = !out_valid_r || out_ready;
  assign cnt       = 3'($countones(used_cur));
  assign cap_eff   = (cap_r == 3'd0) ? 3'd1 : ((cap_r > 3'(NS)) ? 3'(NS) : cap_r);
  assign split_fail = biu_r[eht_pkg::CNT_W-1] ||
                      ((dep_q >= dd_r) && (dd_r == LD_W_C'(DB)));

  always_comb begin
    hit      = '0;
    mv       = '0;
    hit_idx  = '0;
    free_idx = '0;
    for (int s = 0; s < NS; s++) begin
      hit[s] = used_cur[s] && (row_rd[s*SW+VW +: KW] == key_r);
      mv[s]  = used_cur[s] && row_rd[s*SW+VW+int'(dep_q)];
    end
    for (int s = NS-1; s >= 0; s--) begin
      if (hit[s]) begin
        hit_idx = IW'(s);
      end
      if (!used_cur[s]) begin
        free_idx = IW'(s);
      end
    end
  end

  always_comb begin
    pk_row  = row_rd;
    pk_used = '0;
    pos     = '0;
    for (int s = 0; s < NS; s++) begin
      if (mv[s]) begin
        pk_row[int'(pos)*SW +: SW] = row_rd[s*SW +: SW];
        pk_used[pos[IW-1:0]] = 1'b1;
        pos = pos + 3'd1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    dd_nxt        = dd_r;
    biu_nxt       = biu_r;
    b_nxt         = b_r;
    nb_nxt        = nb_r;
    i_nxt         = i_r;
    bit_nxt       = bit_r;
    ddold_nxt     = ddold_r;
    ldn_nxt       = ldn_r;
    dbl_nxt       = dbl_r;
    rst_st_nxt    = rst_st_r;
    res_rv_nxt    = res_rv_r;
    res_ld_nxt    = res_ld_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    dir_we = 1'b0;
    dir_wa = i_r;
    dir_wd = '0;
    dir_ra = key_r[DB-1:0] & lmask;
    bkt_we = 1'b0;
    bkt_wa = b_r;
    bkt_ra = dir_q;
    row_wd = row_rd;
    used_wr = used_cur;
    dep_wr = dep_q;
    case (state_r)
      S_IDLE: begin
        dir_ra = (in_data.command == eht_pkg::CMD_DEPTH) ? in_data.dir_sel
                 : (in_data.key[DB-1:0] & lmask);
        if (accept) begin
          rst_st_nxt = eht_pkg::ST_OK;
          res_rv_nxt = '0;
          res_ld_nxt = '0;
          if ((in_data.command == eht_pkg::CMD_DEPTH) && (in_data.dir_sel > lmask)) begin
            rst_st_nxt = eht_pkg::ST_ABSENT;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_DIR;
          end
        end
      end
      S_LOOK: begin
        state_nxt = S_DIR;
      end
      S_DIR: begin
        b_nxt     = dir_q;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        bkt_ra    = b_r;
        state_nxt = S_RESP;
        case (cmd_r)
          eht_pkg::CMD_FIND: begin
            if (|hit) begin
              res_rv_nxt = row_rd[int'(hit_idx)*SW +: VW];
            end else begin
              rst_st_nxt = eht_pkg::ST_ABSENT;
            end
          end
          eht_pkg::CMD_REMOVE: begin
            if (|hit) begin
              bkt_we           = 1'b1;
              used_wr[hit_idx] = 1'b0;
            end else begin
              rst_st_nxt = eht_pkg::ST_ABSENT;
            end
          end
          eht_pkg::CMD_DEPTH: begin
            res_ld_nxt = dep_q;
          end
          default: begin
            if (|hit) begin
              bkt_we = 1'b1;
              row_wd[int'(hit_idx)*SW +: VW] = val_r;
            end else if (cnt < cap_eff) begin
              bkt_we = 1'b1;
              row_wd[int'(free_idx)*SW +: SW] = {key_r, val_r};
              used_wr[free_idx] = 1'b1;
            end else if (split_fail) begin
              rst_st_nxt = eht_pkg::ST_NOROOM;
            end else begin
              dbl_nxt   = (dep_q >= dd_r);
              ddold_nxt = dd_r;
              dd_nxt    = (dep_q >= dd_r) ? dd_r + 3'd1 : dd_r;
              nb_nxt    = biu_r[DB-1:0];
              biu_nxt   = biu_r + 7'd1;
              bit_nxt   = dep_q;
              ldn_nxt   = dep_q + 3'd1;
              bkt_we    = 1'b1;
              bkt_wa    = biu_r[DB-1:0];
              row_wd    = pk_row;
              used_wr   = pk_used;
              dep_wr    = dep_q + 3'd1;
              i_nxt     = depth_mask(dd_nxt);
              state_nxt = S_DEP2;
            end
          end
        endcase
      end
      S_DEP2: begin
        bkt_we    = 1'b1;
        bkt_wa    = b_r;
        dep_wr    = ldn_r;
        used_wr   = used_cur & ~mv;
        state_nxt = S_SWR;
      end
      S_SWR: begin
        dir_ra    = dbl_r ? (i_r & omask) : i_r;
        state_nxt = S_SWW;
      end
      S_SWW: begin
        dir_we = 1'b1;
        dir_wa = i_r;
        dir_wd = ((dir_q == b_r) && ((i_r >> bit_r) & DB'(1)) != '0) ? nb_r : dir_q;
        if (i_r == '0) begin
          state_nxt = S_LOOK;
        end else begin
          i_nxt     = i_r - DB'(1);
          state_nxt = S_SWR;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: rst_st_r, read_value: res_rv_r, bkt_level: res_ld_r,
                            dir_level: dd_r, bucket_count: biu_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    bkt_wd = {dep_wr, used_wr, row_wd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dd_r        <= '0;
      biu_r       <= 7'd1;
      cap_r       <= eht_pkg::CAP_RESET;
      dir_vld_r   <= '0;
      bkt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dd_r        <= dd_nxt;
      biu_r       <= biu_nxt;
      out_valid_r <= out_valid_nxt;
      if (dir_we) begin
        dir_vld_r[dir_wa] <= 1'b1;
      end
      if (bkt_we) begin
        bkt_vld_r[bkt_wa] <= 1'b1;
      end
      if (psel && penable && pwrite && !paddr[2]) begin
        cap_r <= pwdata[eht_pkg::CAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data.command;
      key_r <= in_data.key;
      val_r <= in_data.write_value;
    end
    rd_dir_vld_r <= dir_vld_r[dir_ra];
    rd_bkt_vld_r <= bkt_vld_r[bkt_ra];
    b_r          <= b_nxt;
    nb_r         <= nb_nxt;
    i_r          <= i_nxt;
    bit_r        <= bit_nxt;
    ddold_r      <= ddold_nxt;
    ldn_r        <= ldn_nxt;
    dbl_r        <= dbl_nxt;
    rst_st_r     <= rst_st_nxt;
    res_rv_r     <= res_rv_nxt;
    res_ld_r     <= res_ld_nxt;
    out_data_r   <= out_data_nxt;
  end

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    dd_r <= LD_W_C'(DB))
    else $error("global depth above maximum");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (biu_r >= 7'd1) && (biu_r <= 7'(eht_pkg::DIR_ENTRIES)))
    else $error("bucket count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROW) && (state_nxt == S_DEP2) |=> (biu_r == $past(biu_r) + 7'd1))
    else $error("split did not allocate exactly one bucket");

  a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_ROW) |=> $stable(dd_r))
    else $error("global depth changed outside a split");

  a_sweep_writes: assert property (@(posedge clk) disable iff (!rst_n)
    dir_we |-> (state_r == S_SWW))
    else $error("directory written outside the sweep");

endmodule
